[sv/tsrtp_pkg.sv]
// ----------------------------------------------------------------------------
// tsrtp_pkg
// Shared widths, word types, register indexes and tables of the time scaled
// rotate and translate point pipeline.
// ----------------------------------------------------------------------------
package tsrtp_pkg;

  localparam int CoordWidth   = 32;
  localparam int TimeWidth    = 32;
  localparam int TimeFrac     = 16;
  localparam int RateWidth    = 32;
  localparam int CfgDataWidth = 32;
  localparam int CfgIdxWidth  = 2;
  localparam int CordicSteps  = 24;

  localparam int ProdWidth  = TimeWidth + RateWidth;
  localparam int AngleBits  = 32;
  localparam int AngleWidth = AngleBits + 2;
  localparam int DriftWidth = ProdWidth - TimeFrac;
  localparam int RelWidth   = CoordWidth + 1;
  localparam int OffsWidth  = ((DriftWidth > CoordWidth) ? DriftWidth : CoordWidth) + 1;

  localparam int TrigFrac     = (CoordWidth <= 32) ? 30 : 62 - CoordWidth;
  localparam int TrigWidth    = TrigFrac + 3;
  localparam int RotProdWidth = TrigWidth + RelWidth;
  localparam int RotSumWidth  = RotProdWidth + 1;
  localparam int RotWidth     = RotSumWidth - TrigFrac;
  localparam int MoveWidth    = ((RotWidth > OffsWidth) ? RotWidth : OffsWidth) + 1;

  localparam longint CordicGainQ30 = 652032874;
  localparam logic signed [TrigWidth-1:0] CordicX0 =
    TrigWidth'(CordicGainQ30 >> (30 - TrigFrac));

  localparam logic signed [AngleWidth-1:0] QuarterTurn = AngleWidth'(64'sd1 << (AngleBits - 2));
  localparam logic signed [AngleWidth-1:0] HalfTurn    = AngleWidth'(64'sd1 << (AngleBits - 1));

  localparam logic signed [RotSumWidth-1:0] HalfUlp = RotSumWidth'(1) << (TrigFrac - 1);

  localparam int unsigned AtanBam [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1, 0
  };

  typedef enum logic [CfgIdxWidth-1:0] {
    RegAngleRate = 2'd0,
    RegDriftX    = 2'd1,
    RegDriftY    = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic signed [TimeWidth-1:0]  time_offset;
    logic signed [CoordWidth-1:0] point_x;
    logic signed [CoordWidth-1:0] point_y;
    logic signed [CoordWidth-1:0] pivot_x;
    logic signed [CoordWidth-1:0] pivot_y;
  } in_word_t;

  typedef struct packed {
    logic signed [CoordWidth-1:0] moved_x;
    logic signed [CoordWidth-1:0] moved_y;
    logic                         overflow;
  } out_word_t;

  typedef struct packed {
    logic                        neg;
    logic signed [RelWidth-1:0]  rel_x;
    logic signed [RelWidth-1:0]  rel_y;
    logic signed [OffsWidth-1:0] offs_x;
    logic signed [OffsWidth-1:0] offs_y;
  } side_t;

endpackage

[sv/time_scaled_rotate_translate_point_top.sv]
// ----------------------------------------------------------------------------
// time_scaled_rotate_translate_point_top
// Rotate a point about a center by a time scaled angle, shift it by a time
// scaled drift, and saturate the result.
//
// Takes one word per clock and returns one word per clock, in order, while
// the output does not stall. Two stages form the angle and the drift
// offsets, CORDIC_STEPS stages of micro-rotation give cosine and sine, and
// three stages multiply, round and saturate. Every stage holds its own word
// when the output stalls, so bubbles close up and input keeps flowing until
// the whole pipeline is full. Write the rate registers only while no word is
// in flight.
// ----------------------------------------------------------------------------
module time_scaled_rotate_translate_point_top #(
  parameter int CORDIC_STEPS = tsrtp_pkg::CordicSteps
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [tsrtp_pkg::CfgIdxWidth-1:0]     cfg_idx_i,
  input  logic [tsrtp_pkg::CfgDataWidth-1:0]    cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  tsrtp_pkg::in_word_t                   in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output tsrtp_pkg::out_word_t                  out_data_o
);

  localparam int RW = tsrtp_pkg::RateWidth;
  localparam int CW = tsrtp_pkg::CoordWidth;

  logic signed [RW-1:0] angle_rate_d, angle_rate_q;
  logic signed [RW-1:0] drift_x_d, drift_x_q;
  logic signed [RW-1:0] drift_y_d, drift_y_q;

  logic                                  sc_valid, sc_ready;
  logic signed [tsrtp_pkg::AngleWidth-1:0] sc_angle;
  tsrtp_pkg::side_t                      sc_side;

  logic                                  cd_valid, cd_ready;
  logic signed [tsrtp_pkg::TrigWidth-1:0]  cd_cos, cd_sin;
  tsrtp_pkg::side_t                      cd_side;

  always_comb begin
    angle_rate_d = angle_rate_q;
    drift_x_d    = drift_x_q;
    drift_y_d    = drift_y_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        tsrtp_pkg::RegAngleRate: angle_rate_d = RW'($signed(cfg_data_i));
        tsrtp_pkg::RegDriftX:    drift_x_d    = RW'($signed(cfg_data_i));
        tsrtp_pkg::RegDriftY:    drift_y_d    = RW'($signed(cfg_data_i));
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_rate_q <= '0;
      drift_x_q    <= '0;
      drift_y_q    <= '0;
    end else begin
      angle_rate_q <= angle_rate_d;
      drift_x_q    <= drift_x_d;
      drift_y_q    <= drift_y_d;
    end
  end

  tsrtp_scale u_scale (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .angle_rate_i   (angle_rate_q),
    .drift_rate_x_i (drift_x_q),
    .drift_rate_y_i (drift_y_q),
    .valid_i        (in_valid_i),
    .ready_o        (in_ready_o),
    .data_i         (in_data_i),
    .valid_o        (sc_valid),
    .ready_i        (sc_ready),
    .angle_o        (sc_angle),
    .side_o         (sc_side)
  );

  tsrtp_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sc_valid),
    .ready_o (sc_ready),
    .angle_i (sc_angle),
    .side_i  (sc_side),
    .valid_o (cd_valid),
    .ready_i (cd_ready),
    .cos_o   (cd_cos),
    .sin_o   (cd_sin),
    .side_o  (cd_side)
  );

  tsrtp_rotate u_rotate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cd_valid),
    .ready_o (cd_ready),
    .cos_i   (cd_cos),
    .sin_i   (cd_sin),
    .side_i  (cd_side),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o)
  );

`ifndef NO_ASSERTIONS
  localparam logic signed [CW-1:0] ChkMax = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] ChkMin = {1'b1, {(CW-1){1'b0}}};

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled while the output register can move");

  a_overflow_at_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.overflow) |->
      (out_data_o.moved_x == ChkMax || out_data_o.moved_x == ChkMin ||
       out_data_o.moved_y == ChkMax || out_data_o.moved_y == ChkMin))
    else $error("overflow flagged without a saturated coordinate");

  a_cfg_unused_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && cfg_idx_i > tsrtp_pkg::RegDriftY) |=>
      ($stable(angle_rate_q) && $stable(drift_x_q) && $stable(drift_y_q)))
    else $error("write to an unused register index changed a rate");
`endif

endmodule

[sv/tsrtp_scale.sv]
// ----------------------------------------------------------------------------
// tsrtp_scale
// Two stages: time products and relative point, then angle fold and offsets.
// ----------------------------------------------------------------------------
module tsrtp_scale (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic signed [tsrtp_pkg::RateWidth-1:0]    angle_rate_i,
  input  logic signed [tsrtp_pkg::RateWidth-1:0]    drift_rate_x_i,
  input  logic signed [tsrtp_pkg::RateWidth-1:0]    drift_rate_y_i,
  input  logic                                      valid_i,
  output logic                                      ready_o,
  input  tsrtp_pkg::in_word_t                       data_i,
  output logic                                      valid_o,
  input  logic                                      ready_i,
  output logic signed [tsrtp_pkg::AngleWidth-1:0]   angle_o,
  output tsrtp_pkg::side_t                          side_o
);

  localparam int PW = tsrtp_pkg::ProdWidth;
  localparam int AW = tsrtp_pkg::AngleWidth;
  localparam int RW = tsrtp_pkg::RelWidth;
  localparam int OW = tsrtp_pkg::OffsWidth;
  localparam int CW = tsrtp_pkg::CoordWidth;
  localparam int TF = tsrtp_pkg::TimeFrac;

  logic vld0_q, vld1_q, rdy0, rdy1;

  logic signed [PW-1:0] p_ang_d, p_ang_q, p_dx_d, p_dx_q, p_dy_d, p_dy_q;
  logic signed [RW-1:0] rel_x_d, rel_x_q, rel_y_d, rel_y_q;
  logic signed [CW-1:0] cx_q, cy_q;

  logic [tsrtp_pkg::AngleBits-1:0]            ang_bits;
  logic signed [AW-1:0]                       ang_raw, angle_d, angle_q;
  logic signed [tsrtp_pkg::DriftWidth-1:0]    dx, dy;
  tsrtp_pkg::side_t                           side_d, side_q;

  assign rdy1    = !vld1_q || ready_i;
  assign rdy0    = !vld0_q || rdy1;
  assign ready_o = rdy0;

  assign p_ang_d = data_i.time_offset * angle_rate_i;
  assign p_dx_d  = data_i.time_offset * drift_rate_x_i;
  assign p_dy_d  = data_i.time_offset * drift_rate_y_i;
  assign rel_x_d = RW'(data_i.point_x) - RW'(data_i.pivot_x);
  assign rel_y_d = RW'(data_i.point_y) - RW'(data_i.pivot_y);

  always_comb begin
    ang_bits = p_ang_q[TF+tsrtp_pkg::AngleBits-1:TF];
    ang_raw  = AW'($signed(ang_bits));
    dx       = p_dx_q[PW-1:TF];
    dy       = p_dy_q[PW-1:TF];
    side_d.rel_x  = rel_x_q;
    side_d.rel_y  = rel_y_q;
    side_d.offs_x = OW'(dx) + OW'(cx_q);
    side_d.offs_y = OW'(dy) + OW'(cy_q);
    if (ang_raw > tsrtp_pkg::QuarterTurn) begin
      angle_d    = ang_raw - tsrtp_pkg::HalfTurn;
      side_d.neg = 1'b1;
    end else if (ang_raw < -tsrtp_pkg::QuarterTurn) begin
      angle_d    = ang_raw + tsrtp_pkg::HalfTurn;
      side_d.neg = 1'b1;
    end else begin
      angle_d    = ang_raw;
      side_d.neg = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
      vld1_q <= 1'b0;
    end else begin
      if (rdy0) vld0_q <= valid_i;
      if (rdy1) vld1_q <= vld0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy0 && valid_i) begin
      p_ang_q <= p_ang_d;
      p_dx_q  <= p_dx_d;
      p_dy_q  <= p_dy_d;
      rel_x_q <= rel_x_d;
      rel_y_q <= rel_y_d;
      cx_q    <= data_i.pivot_x;
      cy_q    <= data_i.pivot_y;
    end
    if (rdy1 && vld0_q) begin
      angle_q <= angle_d;
      side_q  <= side_d;
    end
  end

  assign valid_o = vld1_q;
  assign angle_o = angle_q;
  assign side_o  = side_q;

endmodule

[sv/tsrtp_cordic.sv]
// ----------------------------------------------------------------------------
// tsrtp_cordic
// Rotation-mode CORDIC, one micro-rotation per register stage.
// ----------------------------------------------------------------------------
module tsrtp_cordic #(
  parameter int CORDIC_STEPS = tsrtp_pkg::CordicSteps
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     valid_i,
  output logic                                     ready_o,
  input  logic signed [tsrtp_pkg::AngleWidth-1:0]  angle_i,
  input  tsrtp_pkg::side_t                         side_i,
  output logic                                     valid_o,
  input  logic                                     ready_i,
  output logic signed [tsrtp_pkg::TrigWidth-1:0]   cos_o,
  output logic signed [tsrtp_pkg::TrigWidth-1:0]   sin_o,
  output tsrtp_pkg::side_t                         side_o
);

  localparam int TW = tsrtp_pkg::TrigWidth;
  localparam int AW = tsrtp_pkg::AngleWidth;

  logic                 vld_q  [CORDIC_STEPS];
  logic                 rdy    [CORDIC_STEPS+1];
  logic signed [TW-1:0] x_q    [CORDIC_STEPS];
  logic signed [TW-1:0] y_q    [CORDIC_STEPS];
  logic signed [AW-1:0] z_q    [CORDIC_STEPS-1];
  tsrtp_pkg::side_t     side_q [CORDIC_STEPS];

  assign rdy[CORDIC_STEPS] = ready_i;

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    logic                 v_in;
    logic signed [TW-1:0] x_in, y_in, x_d, y_d;
    logic signed [AW-1:0] z_in;
    tsrtp_pkg::side_t     side_in;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign x_in    = tsrtp_pkg::CordicX0;
      assign y_in    = '0;
      assign z_in    = angle_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = vld_q[k-1];
      assign x_in    = x_q[k-1];
      assign y_in    = y_q[k-1];
      assign z_in    = z_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign rdy[k] = !vld_q[k] || rdy[k+1];

    always_comb begin
      if (!z_in[AW-1]) begin
        x_d = x_in - (y_in >>> k);
        y_d = y_in + (x_in >>> k);
      end else begin
        x_d = x_in + (y_in >>> k);
        y_d = y_in - (x_in >>> k);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && v_in) begin
        x_q[k]    <= x_d;
        y_q[k]    <= y_d;
        side_q[k] <= side_in;
      end
    end

    if (k < CORDIC_STEPS - 1) begin : g_angle
      logic signed [AW-1:0] z_d;
      logic signed [AW-1:0] atan_k;

      assign atan_k = $signed(AW'(tsrtp_pkg::AtanBam[k]));
      assign z_d    = z_in[AW-1] ? z_in + atan_k : z_in - atan_k;

      always_ff @(posedge clk_i) begin
        if (rdy[k] && v_in) z_q[k] <= z_d;
      end
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = vld_q[CORDIC_STEPS-1];
  assign cos_o   = x_q[CORDIC_STEPS-1];
  assign sin_o   = y_q[CORDIC_STEPS-1];
  assign side_o  = side_q[CORDIC_STEPS-1];

endmodule

[sv/tsrtp_rotate.sv]
// ----------------------------------------------------------------------------
// tsrtp_rotate
// Three stages: rotation products, rounding back to coordinates, then offset
// add with saturation into the output register.
// ----------------------------------------------------------------------------
module tsrtp_rotate (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    valid_i,
  output logic                                    ready_o,
  input  logic signed [tsrtp_pkg::TrigWidth-1:0]  cos_i,
  input  logic signed [tsrtp_pkg::TrigWidth-1:0]  sin_i,
  input  tsrtp_pkg::side_t                        side_i,
  output logic                                    valid_o,
  input  logic                                    ready_i,
  output tsrtp_pkg::out_word_t                    data_o
);

  localparam int TW = tsrtp_pkg::TrigWidth;
  localparam int PW = tsrtp_pkg::RotProdWidth;
  localparam int SW = tsrtp_pkg::RotSumWidth;
  localparam int QW = tsrtp_pkg::RotWidth;
  localparam int OW = tsrtp_pkg::OffsWidth;
  localparam int MW = tsrtp_pkg::MoveWidth;
  localparam int CW = tsrtp_pkg::CoordWidth;

  localparam logic signed [CW-1:0] CoordMax = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CoordMin = {1'b1, {(CW-1){1'b0}}};

  function automatic logic [CW:0] saturate(input logic signed [MW-1:0] v);
    logic fits;
    fits = (v == MW'($signed(v[CW-1:0])));
    if (fits) begin
      return {1'b0, v[CW-1:0]};
    end else if (v[MW-1]) begin
      return {1'b1, CoordMin};
    end else begin
      return {1'b1, CoordMax};
    end
  endfunction

  logic vld0_q, vld1_q, vld2_q, rdy0, rdy1, rdy2;

  logic signed [TW-1:0] c, s;
  logic signed [PW-1:0] p_cx_d, p_cx_q, p_sy_d, p_sy_q, p_sx_d, p_sx_q, p_cy_d, p_cy_q;
  logic signed [OW-1:0] offs_x0_q, offs_y0_q, offs_x1_q, offs_y1_q;
  logic signed [SW-1:0] sum_x, sum_y;
  logic signed [QW-1:0] rot_x_d, rot_x_q, rot_y_d, rot_y_q;
  logic signed [MW-1:0] move_x, move_y;
  logic [CW:0]          sat_x, sat_y;
  tsrtp_pkg::out_word_t out_d, out_q;

  assign rdy2    = !vld2_q || ready_i;
  assign rdy1    = !vld1_q || rdy2;
  assign rdy0    = !vld0_q || rdy1;
  assign ready_o = rdy0;

  assign c      = side_i.neg ? -cos_i : cos_i;
  assign s      = side_i.neg ? -sin_i : sin_i;
  assign p_cx_d = c * side_i.rel_x;
  assign p_sy_d = s * side_i.rel_y;
  assign p_sx_d = s * side_i.rel_x;
  assign p_cy_d = c * side_i.rel_y;

  assign sum_x   = SW'(p_cx_q) - SW'(p_sy_q) + tsrtp_pkg::HalfUlp;
  assign sum_y   = SW'(p_sx_q) + SW'(p_cy_q) + tsrtp_pkg::HalfUlp;
  assign rot_x_d = QW'(sum_x >>> tsrtp_pkg::TrigFrac);
  assign rot_y_d = QW'(sum_y >>> tsrtp_pkg::TrigFrac);

  always_comb begin
    move_x         = MW'(rot_x_q) + MW'(offs_x1_q);
    move_y         = MW'(rot_y_q) + MW'(offs_y1_q);
    sat_x          = saturate(move_x);
    sat_y          = saturate(move_y);
    out_d.moved_x  = sat_x[CW-1:0];
    out_d.moved_y  = sat_y[CW-1:0];
    out_d.overflow = sat_x[CW] | sat_y[CW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else begin
      if (rdy0) vld0_q <= valid_i;
      if (rdy1) vld1_q <= vld0_q;
      if (rdy2) vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy0 && valid_i) begin
      p_cx_q    <= p_cx_d;
      p_sy_q    <= p_sy_d;
      p_sx_q    <= p_sx_d;
      p_cy_q    <= p_cy_d;
      offs_x0_q <= side_i.offs_x;
      offs_y0_q <= side_i.offs_y;
    end
    if (rdy1 && vld0_q) begin
      rot_x_q   <= rot_x_d;
      rot_y_q   <= rot_y_d;
      offs_x1_q <= offs_x0_q;
      offs_y1_q <= offs_y0_q;
    end
    if (rdy2 && vld1_q) begin
      out_q <= out_d;
    end
  end

  assign valid_o = vld2_q;
  assign data_o  = out_q;

endmodule
